### hw/rtl/hs_pkg.sv
// Heap sorter package: sizes, sequencer state type and the request and status
// structs shared by the top level and the sort sequencer. No dependencies.
`timescale 1ns / 1ps

package hs_pkg;

  localparam int MAX_ITEMS = 64;
  localparam int DATA_W    = 32;
  localparam int IDX_W     = $clog2(MAX_ITEMS);
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
  // child indexes of any node fit here without wrapping
  localparam int SIFT_W    = IDX_W + 2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_B_FETCH,
    ST_B_LOAD,
    ST_S_RD,
    ST_S_CMP1,
    ST_S_CMP2,
    ST_X_RD,
    ST_X_LOAD,
    ST_O_RD,
    ST_O_LD
  } seq_state_e;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
  } ram_req_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic last;
  } seq_stat_t;

endpackage

### hw/rtl/hs_if.sv
// Valid/ready channel interfaces of the heap sorter.
// Depends on hs_pkg for the data width.
`timescale 1ns / 1ps

interface hs_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [hs_pkg::DATA_W-1:0] value;
  logic                             last_in;

  modport source (output valid, output value, output last_in, input ready);
  modport sink   (input valid, input value, input last_in, output ready);
endinterface

interface hs_out_if;
  logic                             valid;
  logic                             ready;
  logic signed [hs_pkg::DATA_W-1:0] sorted_value;
  logic                             last_out;
  logic                             truncated;

  modport source (output valid, output sorted_value, output last_out, output truncated,
                  input ready);
  modport sink   (input valid, input sorted_value, input last_out, input truncated,
                  output ready);
endinterface

### hw/rtl/hs_ram.sv
// Element store: one write port, two read ports with registered read data.
// Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_ram (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [hs_pkg::IDX_W-1:0]  waddr_i,
  input  logic [hs_pkg::DATA_W-1:0] wdata_i,
  input  logic [hs_pkg::IDX_W-1:0]  raddr_a_i,
  input  logic [hs_pkg::IDX_W-1:0]  raddr_b_i,
  output logic [hs_pkg::DATA_W-1:0] rdata_a_o,
  output logic [hs_pkg::DATA_W-1:0] rdata_b_o
);

  logic [hs_pkg::DATA_W-1:0] mem [hs_pkg::MAX_ITEMS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem[raddr_a_i];
    rdata_b_o <= mem[raddr_b_i];
  end

endmodule

### hw/rtl/hs_seq.sv
// Sort sequencer: heap build, extract passes and readout, all through one
// shared signed comparator and the store ports. Depends on hs_pkg.
`timescale 1ns / 1ps

module hs_seq (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [hs_pkg::CNT_W-1:0]  n_i,
  input  logic                      out_free_i,
  input  logic [hs_pkg::DATA_W-1:0] rd_a_i,
  input  logic [hs_pkg::DATA_W-1:0] rd_b_i,
  output hs_pkg::ram_req_t          ram_req_o,
  output hs_pkg::seq_stat_t         stat_o
);

  hs_pkg::seq_state_e state_q, state_d;

  logic [hs_pkg::CNT_W-1:0]  n_q, n_d;
  logic [hs_pkg::CNT_W-1:0]  size_q, size_d;
  logic [hs_pkg::CNT_W-1:0]  iter_q, iter_d;
  logic [hs_pkg::IDX_W-1:0]  node_q, node_d;
  logic [hs_pkg::DATA_W-1:0] val_q, val_d;
  logic [hs_pkg::DATA_W-1:0] cand_val_q, cand_val_d;
  logic [hs_pkg::IDX_W-1:0]  cand_idx_q, cand_idx_d;
  logic                      build_q, build_d;
  logic [hs_pkg::IDX_W-1:0]  k_q, k_d;

  logic [hs_pkg::CNT_W-1:0]  iter_m1;
  logic [hs_pkg::CNT_W-1:0]  half_n;
  logic [hs_pkg::SIFT_W-1:0] left_idx, right_idx, size_ext;
  logic                      right_ok;
  logic signed [hs_pkg::DATA_W-1:0] cmp_a, cmp_b;
  logic                      gt;
  logic                      sift_end;

  assign iter_m1   = iter_q - hs_pkg::CNT_W'(1);
  assign half_n    = n_i >> 1;
  assign left_idx  = hs_pkg::SIFT_W'({node_q, 1'b1});
  assign right_idx = left_idx + hs_pkg::SIFT_W'(1);
  assign size_ext  = hs_pkg::SIFT_W'(size_q);
  assign right_ok  = right_idx < size_ext;
  // the one comparator of the block
  assign gt        = cmp_a > cmp_b;

  always_comb begin
    state_d    = state_q;
    n_d        = n_q;
    size_d     = size_q;
    iter_d     = iter_q;
    node_d     = node_q;
    val_d      = val_q;
    cand_val_d = cand_val_q;
    cand_idx_d = cand_idx_q;
    build_d    = build_q;
    k_d        = k_q;
    ram_req_o  = '0;
    stat_o     = '0;
    sift_end   = 1'b0;
    cmp_a      = rd_b_i;
    cmp_b      = rd_a_i;
    stat_o.busy = (state_q != hs_pkg::ST_IDLE);

    unique case (state_q)
      hs_pkg::ST_IDLE: begin
        if (start_i) begin
          n_d    = n_i;
          size_d = n_i;
          k_d    = '0;
          if (half_n != '0) begin
            iter_d  = half_n;
            build_d = 1'b1;
            state_d = hs_pkg::ST_B_FETCH;
          end else begin
            build_d = 1'b0;
            state_d = hs_pkg::ST_O_RD;
          end
        end
      end
      hs_pkg::ST_B_FETCH: begin
        ram_req_o.raddr_a = iter_m1[hs_pkg::IDX_W-1:0];
        node_d            = iter_m1[hs_pkg::IDX_W-1:0];
        state_d           = hs_pkg::ST_B_LOAD;
      end
      hs_pkg::ST_B_LOAD: begin
        val_d   = rd_a_i;
        state_d = hs_pkg::ST_S_RD;
      end
      hs_pkg::ST_S_RD: begin
        if (left_idx >= size_ext) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = node_q;
          ram_req_o.wdata = val_q;
          sift_end        = 1'b1;
        end else begin
          ram_req_o.raddr_a = left_idx[hs_pkg::IDX_W-1:0];
          ram_req_o.raddr_b = right_idx[hs_pkg::IDX_W-1:0];
          state_d           = hs_pkg::ST_S_CMP1;
        end
      end
      hs_pkg::ST_S_CMP1: begin
        // larger child, left wins ties
        cmp_a = rd_b_i;
        cmp_b = rd_a_i;
        if (right_ok && gt) begin
          cand_val_d = rd_b_i;
          cand_idx_d = right_idx[hs_pkg::IDX_W-1:0];
        end else begin
          cand_val_d = rd_a_i;
          cand_idx_d = left_idx[hs_pkg::IDX_W-1:0];
        end
        state_d = hs_pkg::ST_S_CMP2;
      end
      hs_pkg::ST_S_CMP2: begin
        cmp_a           = cand_val_q;
        cmp_b           = val_q;
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = node_q;
        if (gt) begin
          // child moves up, held value goes one level down
          ram_req_o.wdata = cand_val_q;
          node_d          = cand_idx_q;
          state_d         = hs_pkg::ST_S_RD;
        end else begin
          ram_req_o.wdata = val_q;
          sift_end        = 1'b1;
        end
      end
      hs_pkg::ST_X_RD: begin
        ram_req_o.raddr_a = '0;
        ram_req_o.raddr_b = iter_m1[hs_pkg::IDX_W-1:0];
        state_d           = hs_pkg::ST_X_LOAD;
      end
      hs_pkg::ST_X_LOAD: begin
        // root goes to the end, old end value is sifted down from the root
        val_d           = rd_b_i;
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = iter_m1[hs_pkg::IDX_W-1:0];
        ram_req_o.wdata = rd_a_i;
        size_d          = iter_m1;
        node_d          = '0;
        state_d         = hs_pkg::ST_S_RD;
      end
      hs_pkg::ST_O_RD: begin
        if (out_free_i) begin
          ram_req_o.raddr_a = k_q;
          state_d           = hs_pkg::ST_O_LD;
        end
      end
      hs_pkg::ST_O_LD: begin
        stat_o.emit = 1'b1;
        stat_o.last = (hs_pkg::CNT_W'(k_q) + hs_pkg::CNT_W'(1)) == n_q;
        if (stat_o.last) begin
          state_d = hs_pkg::ST_IDLE;
        end else begin
          k_d     = k_q + hs_pkg::IDX_W'(1);
          state_d = hs_pkg::ST_O_RD;
        end
      end
      default: begin
        state_d = hs_pkg::ST_IDLE;
      end
    endcase

    if (sift_end) begin
      priority if (build_q && iter_q > hs_pkg::CNT_W'(1)) begin
        iter_d  = iter_m1;
        state_d = hs_pkg::ST_B_FETCH;
      end else if (build_q) begin
        iter_d  = n_q;
        build_d = 1'b0;
        state_d = (n_q > hs_pkg::CNT_W'(1)) ? hs_pkg::ST_X_RD : hs_pkg::ST_O_RD;
      end else if (iter_q > hs_pkg::CNT_W'(2)) begin
        iter_d  = iter_m1;
        state_d = hs_pkg::ST_X_RD;
      end else begin
        state_d = hs_pkg::ST_O_RD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hs_pkg::ST_IDLE;
      build_q <= 1'b0;
      n_q     <= '0;
      size_q  <= '0;
      iter_q  <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      build_q <= build_d;
      n_q     <= n_d;
      size_q  <= size_d;
      iter_q  <= iter_d;
      k_q     <= k_d;
    end
  end

  always_ff @(posedge clk_i) begin
    node_q     <= node_d;
    val_q      <= val_d;
    cand_val_q <= cand_val_d;
    cand_idx_q <= cand_idx_d;
  end

  // sort writes stay inside the live heap
  a_wr_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (hs_pkg::CNT_W'(ram_req_o.waddr) < size_q))
    else $error("sort write beyond heap end");

  // a sift step always starts on a node of the heap
  a_node_in_heap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == hs_pkg::ST_S_RD) |-> (hs_pkg::CNT_W'(node_q) < size_q))
    else $error("sift node outside heap");

  // readout never starts on an empty set
  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_o.emit |-> (n_q != '0))
    else $error("emit with empty set");

endmodule

### hw/rtl/heap_sorter.sv
// Heap sorter top level: load path, element count, output register; wraps
// hs_ram and hs_seq. Depends on hs_pkg and hs_if.
`timescale 1ns / 1ps
//
//  channel | dir | modport | payload
//  --------+-----+---------+-------------------------------------
//  in_i    | in  | sink    | value[31:0] signed, last_in
//  out_o   | out | source  | sorted_value[31:0] signed, last_out, truncated
//
//  Loading stores one request per cycle while idle; overflow past 64 is dropped.
//  After last_in the block is busy: each sift-down walks the heap one level at a
//  time through read, child-compare and parent-compare states, plus a read and a
//  load state per node fetch/swap; the pace is set by the single comparator and the two-read/one-write store.
//  Readout loads each result into the output register, waiting while out_o is stalled.
//  Reset clears count, overflow flag, sequencer and output valid; store is not cleared.

module heap_sorter (
  input  logic  clk_i,
  input  logic  rst_ni,
  hs_in_if.sink     in_i,
  hs_out_if.source  out_o
);

  logic [hs_pkg::CNT_W-1:0]  count_q;
  logic                      ovf_q;
  logic                      out_valid_q;
  logic [hs_pkg::DATA_W-1:0] out_val_q;
  logic                      out_last_q;
  logic                      out_trunc_q;

  hs_pkg::ram_req_t  seq_req;
  hs_pkg::seq_stat_t stat;

  logic                      in_acc;
  logic                      room;
  logic                      start;
  logic [hs_pkg::CNT_W-1:0]  n_start;
  logic                      out_free;
  logic                      ram_we;
  logic [hs_pkg::IDX_W-1:0]  ram_waddr;
  logic [hs_pkg::DATA_W-1:0] ram_wdata;
  logic [hs_pkg::DATA_W-1:0] rd_a, rd_b;

  assign in_i.ready = !stat.busy;
  assign in_acc     = in_i.valid && in_i.ready;
  assign room       = count_q < hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS);
  assign start      = in_acc && in_i.last_in;
  assign n_start    = room ? count_q + hs_pkg::CNT_W'(1) : hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS);
  assign out_free   = !out_valid_q || out_o.ready;

  // store is loaded only while the sequencer is idle
  always_comb begin
    if (in_acc && room) begin
      ram_we    = 1'b1;
      ram_waddr = count_q[hs_pkg::IDX_W-1:0];
      ram_wdata = in_i.value;
    end else begin
      ram_we    = seq_req.we;
      ram_waddr = seq_req.waddr;
      ram_wdata = seq_req.wdata;
    end
  end

  hs_ram u_ram (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (ram_waddr),
    .wdata_i   (ram_wdata),
    .raddr_a_i (seq_req.raddr_a),
    .raddr_b_i (seq_req.raddr_b),
    .rdata_a_o (rd_a),
    .rdata_b_o (rd_b)
  );

  hs_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .n_i        (n_start),
    .out_free_i (out_free),
    .rd_a_i     (rd_a),
    .rd_b_i     (rd_b),
    .ram_req_o  (seq_req),
    .stat_o     (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (stat.emit && stat.last) begin
        count_q <= '0;
        ovf_q   <= 1'b0;
      end else if (in_acc) begin
        if (room) begin
          count_q <= count_q + hs_pkg::CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (stat.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stat.emit) begin
      out_val_q   <= rd_a;
      out_last_q  <= stat.last;
      out_trunc_q <= ovf_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.sorted_value = out_val_q;
  assign out_o.last_out     = out_last_q;
  assign out_o.truncated    = out_trunc_q;

  // a pending result is never overwritten
  a_no_clobber: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.emit |-> out_free)
    else $error("output register overwritten");

  // the batch state is cleared once the final result is loaded
  a_batch_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stat.emit && stat.last) |=> (count_q == '0 && !ovf_q))
    else $error("batch state not cleared");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hs_pkg::CNT_W'(hs_pkg::MAX_ITEMS))
    else $error("element count past capacity");

endmodule
